// File: rtl/pdma_pkg.sv
// Shared types, constants and arithmetic helpers for the percent difference
// moment accumulator. No dependencies.
`timescale 1ns / 1ps

package pdma_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIV_W    = 56;   // |c - r| * 100 * 2^16 fits in 56 bits

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [31:0] X_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] X_MIN   = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_CLAMP,
        ST_CNT_GO,
        ST_CNT_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_WB,
        ST_OUT
    } t_state;

    // multiply sequence, in issue order
    typedef enum logic [3:0] {
        M_P1,
        M_TERM,
        M_DN2,
        M_C1,
        M_NN,
        M_CQ,
        M_D1,
        M_D,
        M_E1,
        M_E,
        M_A1,
        M_A,
        M_B1,
        M_B
    } t_mstep;

    localparam int NSTEP = 14;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_32
    } t_shift;

    typedef struct packed {
        logic   load;
        logic   pct_start;
        logic   clamp;
        logic   cnt_start;
        logic   dn_load;
        logic   mul_start;
        logic   res_load;
        t_mstep step;
        logic   wb;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic skip_now;
        logic div_done;
        logic mul_done;
        logic out_free;
    } t_sts;

    function automatic logic [63:0] umag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // add saturating to +-(2^63 - 1)
    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (!s[64] && s[63])
            return SAT_MAX;
        else if (s[64] && (!s[63] || (s[62:0] == 63'd0)))
            return -SAT_MAX;
        else
            return s[63:0];
    endfunction

endpackage

// File: rtl/pdma_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pdma_pkg.
`timescale 1ns / 1ps

module pdma_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pdma_pkg::DIV_W-1:0] i_dividend,
    input  logic [31:0]                i_divisor,
    output logic                       o_done,
    output logic [pdma_pkg::DIV_W-1:0] o_quot
);
    import pdma_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DIV_W-1:0] r_q;
    logic [31:0]      r_rem;
    logic [31:0]      r_dvs;
    logic [32:0]      w_remsh;
    logic [33:0]      w_diff;
    logic             w_qbit;

    assign w_remsh = {r_rem, r_q[DIV_W-1]};
    assign w_diff  = {1'b0, w_remsh} - {2'b00, r_dvs};
    assign w_qbit  = !w_diff[33];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[31:0] : w_remsh[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: rtl/pdma_mul.sv
// Sequential 64x64 magnitude multiplier on one 32x32 array: four partial
// products, then shift, saturate to 2^63-1 and apply sign. Depends on pdma_pkg.
`timescale 1ns / 1ps

module pdma_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_neg,
    input  logic [63:0]              i_a,
    input  logic [63:0]              i_b,
    input  pdma_pkg::t_shift         i_shift,
    output logic                     o_done,
    output logic signed [63:0]       o_sat,
    output logic [63:0]              o_raw
);
    import pdma_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [2:0]         r_idx, n_idx;
    logic [63:0]        r_a, r_b;
    logic               r_neg;
    t_shift             r_shift;
    logic [127:0]       r_acc;
    logic signed [63:0] r_sat;
    logic [63:0]        r_raw;

    logic [31:0]  w_ah, w_bh;
    logic [63:0]  w_pp;
    logic [1:0]   w_pos;
    logic [127:0] w_ppx;
    logic [127:0] w_shd;
    logic [63:0]  w_mag;

    assign w_ah  = r_idx[0] ? r_a[63:32] : r_a[31:0];
    assign w_bh  = r_idx[1] ? r_b[63:32] : r_b[31:0];
    assign w_pp  = w_ah * w_bh;
    assign w_pos = {1'b0, r_idx[0]} + {1'b0, r_idx[1]};
    assign w_ppx = {64'd0, w_pp} << {w_pos, 5'd0};

    always_comb begin
        case (r_shift)
            SH_16:   w_shd = r_acc >> 16;
            SH_32:   w_shd = r_acc >> 32;
            default: w_shd = r_acc;
        endcase
        w_mag = ((|w_shd[127:64]) || w_shd[63]) ? 64'(SAT_MAX) : w_shd[63:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_idx  = r_idx;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (r_busy) begin
            n_idx = r_idx + 1'b1;
            if (r_idx == 3'd4) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a     <= i_a;
            r_b     <= i_b;
            r_neg   <= i_neg;
            r_shift <= i_shift;
            r_acc   <= '0;
        end else if (r_busy) begin
            if (r_idx[2]) begin
                r_raw <= r_acc[63:0];
                r_sat <= r_neg ? -$signed(w_mag) : $signed(w_mag);
            end else begin
                r_acc <= r_acc + w_ppx;
            end
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_raw  = r_raw;

endmodule

// File: rtl/pdma_ctrl.sv
// Sequencer for one sample: percent divide, clamp, count divide, multiply
// chain, write-back, result transfer. Depends on pdma_pkg.
`timescale 1ns / 1ps

module pdma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pdma_pkg::t_sts i_sts,
    output pdma_pkg::t_cmd o_cmd
);
    import pdma_pkg::*;

    t_state r_state, n_state;
    t_mstep r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_PCT_GO;
            ST_PCT_GO:   n_state = i_sts.trivial ? ST_CLAMP : ST_PCT_WAIT;
            ST_PCT_WAIT: if (i_sts.div_done) n_state = ST_CLAMP;
            ST_CLAMP:    n_state = i_sts.skip_now ? ST_OUT : ST_CNT_GO;
            ST_CNT_GO:   n_state = ST_CNT_WAIT;
            ST_CNT_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_MUL_GO;
                    n_step  = M_P1;
                end
            end
            ST_MUL_GO:   n_state = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (i_sts.mul_done) begin
                    if (r_step == M_B) begin
                        n_state = ST_WB;
                    end else begin
                        n_state = ST_MUL_GO;
                        n_step  = t_mstep'(r_step + 1'b1);
                    end
                end
            end
            ST_WB:       n_state = ST_OUT;
            ST_OUT:      if (i_sts.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_step;
        o_in_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_PCT_GO:   o_cmd.pct_start = !i_sts.trivial;
            ST_CLAMP:    o_cmd.clamp = 1'b1;
            ST_CNT_GO:   o_cmd.cnt_start = 1'b1;
            ST_CNT_WAIT: o_cmd.dn_load = i_sts.div_done;
            ST_MUL_GO:   o_cmd.mul_start = 1'b1;
            ST_MUL_WAIT: o_cmd.res_load = i_sts.mul_done;
            ST_WB:       o_cmd.wb = 1'b1;
            ST_OUT:      o_cmd.out_load = i_sts.out_free;
            default:     o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= M_P1;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// File: rtl/pdma_datapath.sv
// Per-channel statistics store, sample working registers, operand selection
// for the shared divider and multiplier, output register.
// Depends on pdma_pkg, pdma_div, pdma_mul.
`timescale 1ns / 1ps

module pdma_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdma_pkg::t_cmd      i_cmd,
    output pdma_pkg::t_sts      o_sts,
    input  logic [3:0]          i_channel,
    input  logic signed [31:0]  i_reference_value,
    input  logic signed [31:0]  i_compared_value,
    input  logic [30:0]         i_clamp_limit,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [31:0]  o_percent_diff,
    output logic                o_skipped,
    output logic [31:0]         o_sample_count,
    output logic signed [47:0]  o_running_mean,
    output logic [62:0]         o_second_moment,
    output logic signed [63:0]  o_third_moment,
    output logic [62:0]         o_fourth_moment,
    output logic signed [31:0]  o_smallest_diff,
    output logic signed [31:0]  o_largest_diff
);
    import pdma_pkg::*;

    localparam logic [8:0] CH_MOD = 9'(CHANNELS);

    // statistics store
    logic [31:0]        s_cnt  [CHANNELS];
    logic signed [47:0] s_mean [CHANNELS];
    logic signed [63:0] s_m2   [CHANNELS];
    logic signed [63:0] s_m3   [CHANNELS];
    logic signed [63:0] s_m4   [CHANNELS];
    logic signed [31:0] s_min  [CHANNELS];
    logic signed [31:0] s_max  [CHANNELS];

    // working copy of the current sample and channel
    logic [CH_W-1:0]    r_ch;
    logic signed [31:0] r_ref, r_cmp;
    logic [31:0]        r_cnt, r_n;
    logic signed [47:0] r_mean;
    logic signed [63:0] r_m2, r_m3, r_m4;
    logic signed [31:0] r_min, r_max, r_x;
    logic               r_skip;
    logic signed [63:0] r_delta, r_dn;
    logic signed [63:0] r_res [NSTEP];
    logic               r_out_valid;

    logic [CH_W-1:0]    w_ld_ch;

    // percent difference and clamp
    logic signed [32:0] w_num;
    logic [32:0]        w_num_mag;
    logic [31:0]        w_ref_mag;
    logic               w_numz, w_refz, w_inf, w_neg, w_skip;
    logic [DIV_W-1:0]   w_mag;
    logic [30:0]        w_lim_mag;
    logic signed [31:0] w_x;
    logic [31:0]        w_n;
    logic signed [63:0] w_delta;

    // divider
    logic               w_div_start, w_div_done;
    logic [DIV_W-1:0]   w_dividend, w_quot, w_pct_dvd;
    logic [31:0]        w_divisor;

    // multiplier
    logic signed [63:0] w_sa, w_sb, w_n1, w_n2, w_n64, w_q, w_mul_sat;
    logic [63:0]        w_ma, w_mb, w_mul_raw;
    logic               w_mneg, w_mul_done;
    t_shift             w_msh;

    // write-back
    logic signed [63:0] w_m4s, w_m4n, w_m3n, w_m2n;
    logic signed [47:0] w_meann;
    logic signed [31:0] w_minn, w_maxn;

    assign w_ld_ch = CH_W'(9'(i_channel) % CH_MOD);

    assign w_num     = {r_cmp[31], r_cmp} - {r_ref[31], r_ref};
    assign w_num_mag = w_num[32] ? 33'(-w_num) : 33'(w_num);
    assign w_ref_mag = r_ref[31] ? 32'(-r_ref) : 32'(r_ref);
    assign w_numz    = (w_num == 33'sd0);
    assign w_refz    = (r_ref == 32'sd0);
    assign w_inf     = !w_numz && w_refz;
    assign w_neg     = !w_numz && (w_refz ? w_num[32] : (w_num[32] ^ r_ref[31]));
    assign w_mag     = (w_numz || w_refz) ? '0 : w_quot;
    // 100 * 2^16 = (64 + 32 + 4) << 16
    assign w_pct_dvd = (DIV_W'(w_num_mag) << 22) + (DIV_W'(w_num_mag) << 21)
                     + (DIV_W'(w_num_mag) << 18);

    always_comb begin
        w_skip    = 1'b0;
        w_lim_mag = '0;
        w_x       = '0;
        if (i_clamp_limit != 31'd0) begin
            w_lim_mag = (w_inf || (w_mag > DIV_W'(i_clamp_limit)))
                      ? i_clamp_limit : w_mag[30:0];
            w_x = w_neg ? -$signed({1'b0, w_lim_mag}) : $signed({1'b0, w_lim_mag});
        end else if (w_inf) begin
            w_skip = 1'b1;
        end else if (w_neg) begin
            w_x = (w_mag > DIV_W'(33'h0_8000_0000)) ? X_MIN : -$signed(w_mag[31:0]);
        end else begin
            w_x = (w_mag > DIV_W'(32'h7FFF_FFFF)) ? X_MAX : $signed(w_mag[31:0]);
        end
    end

    assign w_n     = (r_cnt == 32'hFFFF_FFFF) ? r_cnt : r_cnt + 32'd1;
    assign w_delta = 64'(w_x) - 64'(r_mean);

    assign w_div_start = i_cmd.pct_start || i_cmd.cnt_start;
    assign w_dividend  = i_cmd.pct_start ? w_pct_dvd : DIV_W'(umag64(r_delta));
    assign w_divisor   = i_cmd.pct_start ? w_ref_mag : r_n;

    pdma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_n64 = $signed({32'd0, r_n});
    assign w_n1  = w_n64 - 64'sd1;
    assign w_n2  = w_n64 - 64'sd2;
    // n*n - 3n + 3, wrapping as a 64-bit word
    assign w_q   = r_res[M_NN] - (w_n64 <<< 1) - w_n64 + 64'sd3;

    always_comb begin
        w_sa  = r_dn;
        w_sb  = r_dn;
        w_msh = SH_0;
        case (i_cmd.step)
            M_P1:    begin w_sa = r_delta;      w_sb = r_dn;         w_msh = SH_16; end
            M_TERM:  begin w_sa = r_res[M_P1];  w_sb = w_n1;                        end
            M_DN2:   begin w_sa = r_dn;         w_sb = r_dn;         w_msh = SH_16; end
            M_C1:    begin w_sa = r_res[M_TERM]; w_sb = r_res[M_DN2]; w_msh = SH_32; end
            M_NN:    begin w_sa = w_n64;        w_sb = w_n64;                       end
            M_CQ:    begin w_sa = r_res[M_C1];  w_sb = w_q;                         end
            M_D1:    begin w_sa = r_res[M_DN2]; w_sb = r_m2;         w_msh = SH_32; end
            M_D:     begin w_sa = r_res[M_D1];  w_sb = 64'sd6;                      end
            M_E1:    begin w_sa = r_dn;         w_sb = r_m3;         w_msh = SH_16; end
            M_E:     begin w_sa = r_res[M_E1];  w_sb = 64'sd4;                      end
            M_A1:    begin w_sa = r_res[M_TERM]; w_sb = r_dn;        w_msh = SH_32; end
            M_A:     begin w_sa = r_res[M_A1];  w_sb = w_n2;                        end
            M_B1:    begin w_sa = r_dn;         w_sb = r_m2;         w_msh = SH_32; end
            M_B:     begin w_sa = r_res[M_B1];  w_sb = 64'sd3;                      end
            default: begin w_sa = r_dn;         w_sb = r_dn;                        end
        endcase
        w_ma = umag64(w_sa);
        // the quartic count factor is an unsigned word
        if (i_cmd.step == M_CQ) begin
            w_mb   = w_sb;
            w_mneg = w_sa[63];
        end else begin
            w_mb   = umag64(w_sb);
            w_mneg = w_sa[63] ^ w_sb[63];
        end
    end

    pdma_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_neg   (w_mneg),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_shift (w_msh),
        .o_done  (w_mul_done),
        .o_sat   (w_mul_sat),
        .o_raw   (w_mul_raw)
    );

    assign w_m4s   = sadd64(r_m4, sadd64(r_res[M_CQ], sadd64(r_res[M_D], -r_res[M_E])));
    assign w_m4n   = w_m4s[63] ? 64'sd0 : w_m4s;
    assign w_m3n   = sadd64(r_m3, sadd64(r_res[M_A], -r_res[M_B]));
    assign w_m2n   = sadd64(r_m2, r_res[M_TERM]);
    assign w_meann = r_mean + r_dn[47:0];
    assign w_minn  = (r_x < r_min) ? r_x : r_min;
    assign w_maxn  = (r_x > r_max) ? r_x : r_max;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= w_ld_ch;
            r_ref  <= i_reference_value;
            r_cmp  <= i_compared_value;
            r_cnt  <= s_cnt[w_ld_ch];
            r_mean <= s_mean[w_ld_ch];
            r_m2   <= s_m2[w_ld_ch];
            r_m3   <= s_m3[w_ld_ch];
            r_m4   <= s_m4[w_ld_ch];
            r_min  <= s_min[w_ld_ch];
            r_max  <= s_max[w_ld_ch];
        end
        if (i_cmd.clamp) begin
            r_x     <= w_x;
            r_skip  <= w_skip;
            r_n     <= w_n;
            r_delta <= w_delta;
        end
        if (i_cmd.dn_load)
            r_dn <= r_delta[63] ? -$signed(64'(w_quot)) : $signed(64'(w_quot));
        if (i_cmd.res_load)
            r_res[i_cmd.step] <= (i_cmd.step == M_NN) ? $signed(w_mul_raw) : w_mul_sat;
        if (i_cmd.wb) begin
            r_cnt  <= r_n;
            r_mean <= w_meann;
            r_m2   <= w_m2n;
            r_m3   <= w_m3n;
            r_m4   <= w_m4n;
            r_min  <= w_minn;
            r_max  <= w_maxn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                s_cnt[i]  <= '0;
                s_mean[i] <= '0;
                s_m2[i]   <= '0;
                s_m3[i]   <= '0;
                s_m4[i]   <= '0;
                s_min[i]  <= X_MAX;
                s_max[i]  <= X_MIN;
            end
        end else if (i_cmd.wb) begin
            s_cnt[r_ch]  <= r_n;
            s_mean[r_ch] <= w_meann;
            s_m2[r_ch]   <= w_m2n;
            s_m3[r_ch]   <= w_m3n;
            s_m4[r_ch]   <= w_m4n;
            s_min[r_ch]  <= w_minn;
            s_max[r_ch]  <= w_maxn;
        end
    end

    // result register, frees the input side while a transfer is pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.out_load)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_percent_diff  <= r_x;
            o_skipped       <= r_skip;
            o_sample_count  <= r_cnt;
            o_running_mean  <= r_mean;
            o_second_moment <= r_m2[62:0];
            o_third_moment  <= r_m3;
            o_fourth_moment <= r_m4[62:0];
            o_smallest_diff <= r_min;
            o_largest_diff  <= r_max;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.trivial  = w_numz || w_refz;
    assign o_sts.skip_now = w_skip;
    assign o_sts.div_done = w_div_done;
    assign o_sts.mul_done = w_mul_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

// File: rtl/percent_diff_moment_accumulator_core.sv
// Top level: APB register, controller and datapath of the percent difference
// moment accumulator. Depends on pdma_pkg, pdma_ctrl, pdma_datapath.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_ready      channel, reference, compared
//   result    out        o_out_valid / i_out_ready    percent diff, skip flag, stats
//   config    in         psel / penable / pready      clamp_limit at address 0
//
// A sample that accumulates goes, before the next input transfer is accepted,
// through two bit-serial divides (percent, then delta / count) and
// fourteen passes through the single 32x32 multiplier. A sample with equal
// values or a zero reference skips the percent divide; a skipped sample goes from clamp to output.
// Synchronous active-low reset clears the store.
// A stalled result waits in the output register; the next sample is
// accepted meanwhile and held at the result stage until it frees.
`timescale 1ns / 1ps

module percent_diff_moment_accumulator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_channel,
    input  logic signed [31:0] i_reference_value,
    input  logic signed [31:0] i_compared_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_percent_diff,
    output logic               o_skipped,
    output logic [31:0]        o_sample_count,
    output logic signed [47:0] o_running_mean,
    output logic [62:0]        o_second_moment,
    output logic signed [63:0] o_third_moment,
    output logic [62:0]        o_fourth_moment,
    output logic signed [31:0] o_smallest_diff,
    output logic signed [31:0] o_largest_diff,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pdma_pkg::*;

    localparam logic REG_CLAMP = 1'b0;

    logic [30:0] r_clamp_limit;
    t_cmd        w_cmd;
    t_sts        w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_clamp_limit <= '0;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CLAMP))
            r_clamp_limit <= pwdata[30:0];
    end

    assign prdata = (paddr[2] == REG_CLAMP) ? {1'b0, r_clamp_limit} : 32'd0;

    pdma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pdma_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_channel         (i_channel),
        .i_reference_value (i_reference_value),
        .i_compared_value  (i_compared_value),
        .i_clamp_limit     (r_clamp_limit),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_percent_diff    (o_percent_diff),
        .o_skipped         (o_skipped),
        .o_sample_count    (o_sample_count),
        .o_running_mean    (o_running_mean),
        .o_second_moment   (o_second_moment),
        .o_third_moment    (o_third_moment),
        .o_fourth_moment   (o_fourth_moment),
        .o_smallest_diff   (o_smallest_diff),
        .o_largest_diff    (o_largest_diff)
    );

endmodule
